// ----- design/hijp_pkg.sv -----
// Shared types and constants for the hash join probe block.
`default_nettype none

package hijp_pkg;

    localparam int KEY_W      = 32;
    localparam int VAL_W      = 31;
    localparam int SLOT_W     = 12;
    localparam int BIDX_W     = 10;
    localparam int CNT_W      = 7;
    localparam int NUM_W      = 32;
    localparam int RECIP_W    = 32;
    localparam int MOD_STEPS  = 3;
    localparam int MOD_STEP_W = 2;

    typedef enum logic [1:0] {
        REQ_ENTRY  = 2'd0,
        REQ_BUCKET = 2'd1,
        REQ_RIGHT  = 2'd2,
        REQ_PROBE  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_BKT_RD,
        ST_BKT_LAT,
        ST_ENT_RD,
        ST_ENT_CHK,
        ST_ROW_CHK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic load_take;
        logic probe_take;
        logic mod_step;
        logic bkt_rd;
        logic bkt_lat;
        logic ent_rd;
        logic idx_inc;
        logic row_rd;
        logic push;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic is_probe;
        logic clr_done;
        logic mod_done;
        logic scan_end;
        logic slot_oob;
        logic ent_match;
        logic can_push;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ----- design/hijp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module hijp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/hijp_ctrl.sv -----
// Controller state machine: reset clear, loads, bucket hash, bucket scan and flush.
`default_nettype none

module hijp_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire hijp_pkg::stat_t stat,
    output hijp_pkg::cmd_t       cmd
);

    hijp_pkg::state_t state_reg;
    hijp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hijp_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            hijp_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                begin
                    state_next = hijp_pkg::ST_IDLE;
                end
            end
            hijp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (stat.is_probe)
                    begin
                        cmd.probe_take = 1'b1;
                        state_next     = hijp_pkg::ST_HASH;
                    end
                    else
                    begin
                        cmd.load_take = 1'b1;
                    end
                end
            end
            hijp_pkg::ST_HASH:
            begin
                cmd.mod_step = 1'b1;
                if (stat.mod_done)
                begin
                    state_next = hijp_pkg::ST_BKT_RD;
                end
            end
            hijp_pkg::ST_BKT_RD:
            begin
                cmd.bkt_rd = 1'b1;
                state_next = hijp_pkg::ST_BKT_LAT;
            end
            hijp_pkg::ST_BKT_LAT:
            begin
                cmd.bkt_lat = 1'b1;
                state_next  = hijp_pkg::ST_ENT_RD;
            end
            hijp_pkg::ST_ENT_RD:
            begin
                priority if (stat.scan_end)
                begin
                    state_next = hijp_pkg::ST_FLUSH;
                end
                else if (stat.slot_oob)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.ent_rd = 1'b1;
                    state_next = hijp_pkg::ST_ENT_CHK;
                end
            end
            hijp_pkg::ST_ENT_CHK:
            begin
                if (stat.ent_match)
                begin
                    cmd.row_rd = 1'b1;
                    state_next = hijp_pkg::ST_ROW_CHK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = hijp_pkg::ST_ENT_RD;
                end
            end
            hijp_pkg::ST_ROW_CHK:
            begin
                if (stat.can_push)
                begin
                    cmd.push    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = hijp_pkg::ST_ENT_RD;
                end
            end
            hijp_pkg::ST_FLUSH:
            begin
                if (stat.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = hijp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hijp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- design/hijp_datapath.sv -----
// Datapath: the stores, the bucket remainder unit, the scan registers and the result registers.
`default_nettype none

module hijp_datapath #(
    parameter int BUCKETS         = 1024,
    parameter int TABLE_ROWS      = 4096,
    parameter int MAX_BUCKET_FILL = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hijp_pkg::cmd_t                      cmd,
    output hijp_pkg::stat_t                          stat,
    input  wire logic [1:0]                          req_type,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         slot,
    input  wire logic [hijp_pkg::BIDX_W-1:0]         bucket_index,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         bucket_start,
    input  wire logic [hijp_pkg::CNT_W-1:0]          bucket_count,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         entry_row,
    input  wire logic signed [hijp_pkg::KEY_W-1:0]   tuple_key,
    input  wire logic [hijp_pkg::VAL_W-1:0]          tuple_val,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     match_valid,
    output logic signed [hijp_pkg::KEY_W-1:0]        left_key,
    output logic [hijp_pkg::VAL_W-1:0]               left_value,
    output logic signed [hijp_pkg::KEY_W-1:0]        right_key,
    output logic [hijp_pkg::VAL_W-1:0]               right_value,
    output logic [hijp_pkg::NUM_W-1:0]               match_number,
    output logic                                     last
);

    localparam int BAW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int EAW    = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int BKT_W  = hijp_pkg::SLOT_W + hijp_pkg::CNT_W;
    localparam int ENT_W  = hijp_pkg::VAL_W + hijp_pkg::SLOT_W;
    localparam int RGT_W  = hijp_pkg::KEY_W + hijp_pkg::VAL_W;
    localparam int MOD_L  = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam int MOD_SH = hijp_pkg::VAL_W + MOD_L;
    localparam int PROD_W = hijp_pkg::VAL_W + hijp_pkg::RECIP_W;
    localparam logic [hijp_pkg::RECIP_W-1:0] RECIP = hijp_pkg::RECIP_W'(
        ((64'd1 << MOD_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam logic [hijp_pkg::VAL_W-1:0] BKT_VAL  = hijp_pkg::VAL_W'(BUCKETS);
    localparam logic [BAW-1:0] BKT_LAST = BAW'(BUCKETS - 1);
    localparam logic [31:0]    ROWS32   = 32'(TABLE_ROWS);
    localparam logic [31:0]    BKTS32   = 32'(BUCKETS);
    localparam logic [hijp_pkg::CNT_W-1:0] FILL_MAX = hijp_pkg::CNT_W'(MAX_BUCKET_FILL);

    // Clearing pass and bucket remainder unit.
    logic [BAW-1:0]                    clr_cnt_reg;
    logic [PROD_W-1:0]                 mod_prod;
    logic [PROD_W-1:0]                 prod_reg;
    logic [hijp_pkg::VAL_W-1:0]        mod_quo;
    logic [hijp_pkg::VAL_W-1:0]        mod_qd;
    logic [hijp_pkg::VAL_W-1:0]        qd_reg;
    logic [BAW-1:0]                    rem_reg;
    logic [hijp_pkg::MOD_STEP_W-1:0]   mod_cnt_reg;

    // Probe and scan registers.
    logic signed [hijp_pkg::KEY_W-1:0] key_reg;
    logic [hijp_pkg::VAL_W-1:0]        val_reg;
    logic [hijp_pkg::SLOT_W-1:0]       start_reg;
    logic [hijp_pkg::CNT_W-1:0]        count_reg;
    logic [hijp_pkg::CNT_W-1:0]        idx_reg;
    logic [hijp_pkg::NUM_W-1:0]        ctr_reg;
    logic [hijp_pkg::NUM_W-1:0]        ctr_inc;

    // One match is held back until the next match or the end of the scan decides its last flag.
    logic                              held_valid_reg;
    logic signed [hijp_pkg::KEY_W-1:0] held_rkey_reg;
    logic [hijp_pkg::VAL_W-1:0]        held_rval_reg;
    logic [hijp_pkg::NUM_W-1:0]        held_num_reg;

    logic                              out_valid_reg;
    logic                              out_match_reg;
    logic signed [hijp_pkg::KEY_W-1:0] out_lkey_reg;
    logic [hijp_pkg::VAL_W-1:0]        out_lval_reg;
    logic signed [hijp_pkg::KEY_W-1:0] out_rkey_reg;
    logic [hijp_pkg::VAL_W-1:0]        out_rval_reg;
    logic [hijp_pkg::NUM_W-1:0]        out_num_reg;
    logic                              out_last_reg;
    logic                              out_free;

    // Store ports.
    logic             bkt_we;
    logic [BAW-1:0]   bkt_waddr;
    logic [BKT_W-1:0] bkt_wdata;
    logic [BKT_W-1:0] bkt_rdata;
    logic             ent_we;
    logic [ENT_W-1:0] ent_rdata;
    logic             rgt_we;
    logic [RGT_W-1:0] rgt_rdata;

    logic [31:0]      slot_ext;
    logic [31:0]      bidx_ext;
    logic [31:0]      scan_ext;
    logic [31:0]      row_ext;
    logic             slot_ok;
    logic             row_ok;
    logic [hijp_pkg::CNT_W-1:0] fill_sat;
    logic [hijp_pkg::VAL_W-1:0] ent_val;
    logic [hijp_pkg::SLOT_W-1:0] ent_row;

    assign slot_ext = 32'(slot);
    assign bidx_ext = 32'(bucket_index);
    assign scan_ext = 32'(start_reg) + 32'(idx_reg);
    assign ent_val  = ent_rdata[ENT_W-1:hijp_pkg::SLOT_W];
    assign ent_row  = ent_rdata[hijp_pkg::SLOT_W-1:0];
    assign row_ext  = 32'(ent_row);
    assign slot_ok  = slot_ext < ROWS32;
    assign row_ok   = row_ext < ROWS32;
    assign fill_sat = (bucket_count > FILL_MAX) ? FILL_MAX : bucket_count;

    always_comb
    begin
        bkt_we    = 1'b0;
        bkt_waddr = bidx_ext[BAW-1:0];
        bkt_wdata = {bucket_start, fill_sat};
        if (cmd.clr_step)
        begin
            bkt_we    = 1'b1;
            bkt_waddr = clr_cnt_reg;
            bkt_wdata = '0;
        end
        else if (cmd.load_take && (req_type == hijp_pkg::REQ_BUCKET) && (bidx_ext < BKTS32))
        begin
            bkt_we = 1'b1;
        end
    end

    assign ent_we = cmd.load_take && (req_type == hijp_pkg::REQ_ENTRY) && slot_ok;
    assign rgt_we = cmd.load_take && (req_type == hijp_pkg::REQ_RIGHT) && slot_ok;

    hijp_ram #(
        .WIDTH (BKT_W),
        .DEPTH (BUCKETS)
    ) u_bkt_ram (
        .clk   (clk),
        .we    (bkt_we),
        .waddr (bkt_waddr),
        .wdata (bkt_wdata),
        .re    (cmd.bkt_rd),
        .raddr (rem_reg),
        .rdata (bkt_rdata)
    );

    hijp_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_ROWS)
    ) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (slot_ext[EAW-1:0]),
        .wdata ({tuple_val, entry_row}),
        .re    (cmd.ent_rd),
        .raddr (scan_ext[EAW-1:0]),
        .rdata (ent_rdata)
    );

    hijp_ram #(
        .WIDTH (RGT_W),
        .DEPTH (TABLE_ROWS)
    ) u_rgt_ram (
        .clk   (clk),
        .we    (rgt_we),
        .waddr (slot_ext[EAW-1:0]),
        .wdata ({tuple_key, tuple_val}),
        .re    (cmd.row_rd),
        .raddr (row_ext[EAW-1:0]),
        .rdata (rgt_rdata)
    );

    // Remainder by the bucket count through a reciprocal multiply, one step per cycle:
    // the scaled product, then the quotient times BUCKETS, then the subtraction.
    // The reciprocal is rounded up, which keeps the quotient exact for any 31-bit value.
    assign mod_prod = PROD_W'(val_reg) * PROD_W'(RECIP);
    assign mod_quo  = hijp_pkg::VAL_W'(prod_reg >> MOD_SH);
    assign mod_qd   = mod_quo * BKT_VAL;

    assign ctr_inc  = (ctr_reg == '1) ? ctr_reg : ctr_reg + 1'b1;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat.is_probe  = req_type == hijp_pkg::REQ_PROBE;
        stat.clr_done  = clr_cnt_reg == BKT_LAST;
        stat.mod_done  = mod_cnt_reg == hijp_pkg::MOD_STEP_W'(hijp_pkg::MOD_STEPS - 1);
        stat.scan_end  = idx_reg == count_reg;
        stat.slot_oob  = scan_ext >= ROWS32;
        stat.ent_match = ent_val == val_reg;
        stat.can_push  = !held_valid_reg || out_free;
        stat.out_free  = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            mod_cnt_reg    <= '0;
            ctr_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.probe_take)
            begin
                mod_cnt_reg <= '0;
            end
            else if (cmd.mod_step)
            begin
                mod_cnt_reg <= mod_cnt_reg + 1'b1;
            end
            if (cmd.push)
            begin
                ctr_reg        <= ctr_inc;
                held_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                held_valid_reg <= 1'b0;
            end
            if ((cmd.push && held_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_take)
        begin
            key_reg <= tuple_key;
            val_reg <= tuple_val;
        end
        if (cmd.mod_step)
        begin
            prod_reg <= mod_prod;
            qd_reg   <= mod_qd;
            rem_reg  <= BAW'(val_reg - qd_reg);
        end
        if (cmd.bkt_lat)
        begin
            start_reg <= bkt_rdata[BKT_W-1:hijp_pkg::CNT_W];
            count_reg <= bkt_rdata[hijp_pkg::CNT_W-1:0];
            idx_reg   <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.push)
        begin
            held_num_reg <= ctr_inc;
            if (row_ok)
            begin
                held_rkey_reg <= $signed(rgt_rdata[RGT_W-1:hijp_pkg::VAL_W]);
                held_rval_reg <= rgt_rdata[hijp_pkg::VAL_W-1:0];
            end
            else
            begin
                held_rkey_reg <= '0;
                held_rval_reg <= '0;
            end
        end
        if ((cmd.push && held_valid_reg) || (cmd.flush && held_valid_reg))
        begin
            out_match_reg <= 1'b1;
            out_lkey_reg  <= key_reg;
            out_lval_reg  <= val_reg;
            out_rkey_reg  <= held_rkey_reg;
            out_rval_reg  <= held_rval_reg;
            out_num_reg   <= held_num_reg;
            out_last_reg  <= cmd.flush;
        end
        else if (cmd.flush)
        begin
            out_match_reg <= 1'b0;
            out_lkey_reg  <= key_reg;
            out_lval_reg  <= val_reg;
            out_rkey_reg  <= '0;
            out_rval_reg  <= '0;
            out_num_reg   <= ctr_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_valid  = out_match_reg;
    assign left_key     = out_lkey_reg;
    assign left_value   = out_lval_reg;
    assign right_key    = out_rkey_reg;
    assign right_value  = out_rval_reg;
    assign match_number = out_num_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ----- design/hash_index_join_probe.sv -----
// Top level of the hash join probe block: controller plus datapath.
//
// The input channel (in_valid, in_stall) carries one request word: a load of an
// entry slot, of a bucket start and count, of a right table row, or a probe.
// The output channel (out_valid, out_stall) carries result words: one per
// matching entry of the probed bucket, or one word with match_valid clear when
// nothing matched; last marks the final word of each probe.
// A load leaves the block idle and ready for the next request. A probe is
// accepted, then the remainder of the join value by BUCKETS is formed
// (reciprocal multiply, multiply back, subtract), the bucket table is read,
// each scanned entry inside the table is read and checked (a slot past the
// table end is skipped) with a right table read per match, then the end of
// the scan is seen and the final word is flushed.
// The block holds one probe at a time; its input is stalled until the probe's
// final word sits in the output register.
// After reset the bucket table is swept to zero, one bucket per cycle, and the
// input stays stalled until all BUCKETS buckets (1024 by default) are cleared.
// A stalled output holds its word; the scan pauses at a match while one is
// held and the flush waits until the output frees; no word is lost or repeated.
`default_nettype none

module hash_index_join_probe #(
    parameter int BUCKETS         = 1024,
    parameter int TABLE_ROWS      = 4096,
    parameter int MAX_BUCKET_FILL = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         slot,
    input  wire logic [hijp_pkg::BIDX_W-1:0]         bucket_index,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         bucket_start,
    input  wire logic [hijp_pkg::CNT_W-1:0]          bucket_count,
    input  wire logic [hijp_pkg::SLOT_W-1:0]         entry_row,
    input  wire logic signed [hijp_pkg::KEY_W-1:0]   tuple_key,
    input  wire logic [hijp_pkg::VAL_W-1:0]          tuple_val,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     match_valid,
    output logic signed [hijp_pkg::KEY_W-1:0]        left_key,
    output logic [hijp_pkg::VAL_W-1:0]               left_value,
    output logic signed [hijp_pkg::KEY_W-1:0]        right_key,
    output logic [hijp_pkg::VAL_W-1:0]               right_value,
    output logic [hijp_pkg::NUM_W-1:0]               match_number,
    output logic                                     last
);

    hijp_pkg::cmd_t  cmd;
    hijp_pkg::stat_t stat;

    hijp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hijp_datapath #(
        .BUCKETS         (BUCKETS),
        .TABLE_ROWS      (TABLE_ROWS),
        .MAX_BUCKET_FILL (MAX_BUCKET_FILL)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .slot         (slot),
        .bucket_index (bucket_index),
        .bucket_start (bucket_start),
        .bucket_count (bucket_count),
        .entry_row    (entry_row),
        .tuple_key    (tuple_key),
        .tuple_val    (tuple_val),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .match_valid  (match_valid),
        .left_key     (left_key),
        .left_value   (left_value),
        .right_key    (right_key),
        .right_value  (right_value),
        .match_number (match_number),
        .last         (last)
    );

endmodule

`default_nettype wire
